/* rtl/idwr_pkg.sv */
package idwr_pkg;

    localparam int WordBits = 32;

    typedef logic [WordBits-1:0] t_word;

    // One operation as it enters the pipeline.
    typedef struct packed {
        t_word dividend;
        t_word divisor;
        logic  signed_mode;
    } t_op;

    // Working state of one operation between the divide steps.
    typedef struct packed {
        t_word rem;    // partial remainder
        t_word nq;     // dividend bits still to come, quotient bits shifted in below
        t_word den;    // divisor magnitude
        logic  neg_q;  // quotient must be negated at the end
        logic  neg_r;  // remainder must be negated at the end
        logic  dbz;    // divisor was zero
    } t_work;

    // Finished result.
    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  divide_by_zero;
    } t_res;

endpackage

/* rtl/idwr_pre.sv */
module idwr_pre
    import idwr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_op   i_op,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  num_neg;
    logic  den_neg;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        num_neg = i_op.signed_mode & i_op.dividend[WordBits-1];
        den_neg = i_op.signed_mode & i_op.divisor[WordBits-1];
        n_work.rem   = '0;
        n_work.nq    = num_neg ? (~i_op.dividend + t_word'(1)) : i_op.dividend;
        n_work.den   = den_neg ? (~i_op.divisor + t_word'(1)) : i_op.divisor;
        n_work.neg_q = num_neg ^ den_neg;
        n_work.neg_r = num_neg;
        n_work.dbz   = (i_op.divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

/* rtl/idwr_step.sv */
module idwr_step
    import idwr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic              r_valid;
    t_work             r_work;
    t_work             n_work;
    logic [WordBits:0] shifted;
    logic [WordBits:0] diff;

    assign o_ready = !r_valid || i_ready;

    // One restoring step: bring down the next dividend bit and try the subtract.
    // The partial remainder stays below the divisor, so the shifted value fits
    // in one extra bit and the kept remainder fits in a word again.
    always_comb begin
        shifted = {i_work.rem, i_work.nq[WordBits-1]};
        diff    = shifted - {1'b0, i_work.den};
        n_work  = i_work;
        if (!diff[WordBits]) begin
            n_work.rem = diff[WordBits-1:0];
        end else begin
            n_work.rem = shifted[WordBits-1:0];
        end
        n_work.nq = {i_work.nq[WordBits-2:0], ~diff[WordBits]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

/* rtl/idwr_post.sv */
module idwr_post
    import idwr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    logic r_valid;
    t_res r_res;
    t_res n_res;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_work.dbz) begin
            n_res.quotient  = '0;
            n_res.remainder = '0;
        end else begin
            n_res.quotient  = i_work.neg_q ? (~i_work.nq + t_word'(1)) : i_work.nq;
            n_res.remainder = i_work.neg_r ? (~i_work.rem + t_word'(1)) : i_work.rem;
        end
        n_res.divide_by_zero = i_work.dbz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/integer_divide_with_remainder.sv */
// 32-bit signed or unsigned divider with remainder, fully pipelined. A new word
// can be accepted every cycle while the output is not stalled. A first stage
// takes the operand magnitudes, one step stage per quotient bit produces that
// bit with one 33-bit subtract, and a last stage restores the signs. Signed
// quotients truncate toward zero and remainders take the sign of the dividend;
// the most negative value divided by -1 returns itself with remainder zero. A
// zero divisor returns zero for both and raises the divide-by-zero flag. Every
// stage has its own valid bit, so back-pressure fills empty stages before the
// input stalls.
module integer_divide_with_remainder
    import idwr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [2*WordBits-1:0] i_s_axis_tdata,   // dividend, divisor
    input  logic                  i_s_axis_tuser,   // signed_mode
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [2*WordBits-1:0] o_m_axis_tdata,   // quotient, remainder
    output logic                  o_m_axis_tuser    // divide_by_zero
);

    t_op   op;
    t_res  res;
    logic  stage_valid [WordBits+1];
    logic  stage_ready [WordBits+1];
    t_work stage_work  [WordBits+1];

    assign op.dividend    = i_s_axis_tdata[WordBits-1:0];
    assign op.divisor     = i_s_axis_tdata[2*WordBits-1:WordBits];
    assign op.signed_mode = i_s_axis_tuser;

    idwr_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (op),
        .o_valid (stage_valid[0]),
        .i_ready (stage_ready[0]),
        .o_work  (stage_work[0])
    );

    for (genvar k = 0; k < WordBits; k++) begin : g_step
        idwr_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[k]),
            .o_ready (stage_ready[k]),
            .i_work  (stage_work[k]),
            .o_valid (stage_valid[k+1]),
            .i_ready (stage_ready[k+1]),
            .o_work  (stage_work[k+1])
        );
    end

    idwr_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[WordBits]),
        .o_ready (stage_ready[WordBits]),
        .i_work  (stage_work[WordBits]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {res.remainder, res.quotient};
    assign o_m_axis_tuser = res.divide_by_zero;

`ifndef NO_ASSERTIONS
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("divide-by-zero result carries nonzero data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> stage_valid[0])
        else $error("accepted word did not enter the first stage");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid[WordBits] && (stage_work[WordBits].den != '0))
            |-> (stage_work[WordBits].rem < stage_work[WordBits].den))
        else $error("final partial remainder not below divisor");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready && stage_valid[WordBits])
            |-> !stage_ready[WordBits])
        else $error("last step stage drained into a stalled output");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top
    import idwr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomWords   = 1830;
    localparam int PipeLatency   = 34;
    localparam int DrainCycles   = 2 * PipeLatency;
    localparam int HoldOffCycles = 400;
    localparam int HoldOffAfter  = 700;
    localparam int StallLimit    = 4000;
    localparam int MaxPrinted    = 40;

    // Keeps the quotient and remainder expected for every accepted word, oldest first.
    class divide_scoreboard;
        t_res        pending_results[$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned signed_words;
        int unsigned zero_divisors;

        function t_res divide_model(t_op op);
            t_res  r;
            t_word num;
            t_word den;
            t_word quo;
            t_word rem;
            logic  num_neg;
            logic  den_neg;
            r = '0;
            if (op.divisor == '0) begin
                r.divide_by_zero = 1'b1;
                return r;
            end
            num     = op.dividend;
            den     = op.divisor;
            num_neg = op.signed_mode & num[WordBits-1];
            den_neg = op.signed_mode & den[WordBits-1];
            if (num_neg) num = -num;
            if (den_neg) den = -den;
            quo = num / den;
            rem = num % den;
            // The most negative dividend stays itself after negation, so the
            // minus-one case wraps without special handling.
            if (num_neg ^ den_neg) quo = -quo;
            if (num_neg) rem = -rem;
            r.quotient  = quo;
            r.remainder = rem;
            return r;
        endfunction

        task report_mismatch(string msg);
            if (errors < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void note_operands(t_op op);
            pending_results.push_back(divide_model(op));
            words_in++;
            if (op.signed_mode) signed_words++;
            if (op.divisor == '0) zero_divisors++;
        endfunction

        task check_result(t_res got);
            t_res want;
            words_out++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result q=%h r=%h dbz=%b with nothing pending",
                                          got.quotient, got.remainder, got.divide_by_zero));
                return;
            end
            want = pending_results.pop_front();
            if (got.quotient !== want.quotient)
                report_mismatch($sformatf("word %0d quotient %h, expected %h",
                                          words_out, got.quotient, want.quotient));
            if (got.remainder !== want.remainder)
                report_mismatch($sformatf("word %0d remainder %h, expected %h",
                                          words_out, got.remainder, want.remainder));
            if (got.divide_by_zero !== want.divide_by_zero)
                report_mismatch($sformatf("word %0d divide_by_zero %b, expected %b",
                                          words_out, got.divide_by_zero,
                                          want.divide_by_zero));
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [2*WordBits-1:0] i_s_axis_tdata  = '0;  // dividend, divisor
    logic                  i_s_axis_tuser  = 1'b0;  // signed_mode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [2*WordBits-1:0] o_m_axis_tdata;          // quotient, remainder
    logic                  o_m_axis_tuser;          // divide_by_zero

    logic        hold_off = 1'b0;
    logic        no_gaps  = 1'b0;
    int unsigned held_input_cycles;
    int unsigned hold_off_done;

    divide_scoreboard sb = new();

    integer_divide_with_remainder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Both handshakes are sampled at the edge, before any driver update lands.
    always @(posedge i_clk) begin
        t_op  seen_op;
        t_res seen_res;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                seen_op.dividend    = i_s_axis_tdata[WordBits-1:0];
                seen_op.divisor     = i_s_axis_tdata[2*WordBits-1:WordBits];
                seen_op.signed_mode = i_s_axis_tuser;
                sb.note_operands(seen_op);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen_res.quotient       = o_m_axis_tdata[WordBits-1:0];
                seen_res.remainder      = o_m_axis_tdata[2*WordBits-1:WordBits];
                seen_res.divide_by_zero = o_m_axis_tuser;
                sb.check_result(seen_res);
            end
            if (hold_off && i_s_axis_tvalid && !o_s_axis_tready) held_input_cycles++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (no_gaps) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= 14);
        end
    end

    // One long stall on the result side while words keep coming, so the
    // pipeline fills and the input side has to wait.
    initial begin
        while (sb.words_in < HoldOffAfter) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HoldOffCycles) @(posedge i_clk);
        hold_off      <= 1'b0;
        hold_off_done = 1;
    end

    initial begin
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < StallLimit) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Timeout: no word moved for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
    end

    task send_operands(t_word dividend, t_word divisor, logic signed_mode);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 14) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {divisor, dividend};
        i_s_axis_tuser  <= signed_mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    function automatic t_word random_operand();
        t_word corners[8];
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE, 32'h8000_0001};
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom();
            3:       return $urandom() >> $urandom_range(0, 31);
            4:       return t_word'(int'($urandom_range(0, 32)) - 16);
            5:       return corners[$urandom_range(0, 7)];
            6:       return t_word'(1) << $urandom_range(0, 31);
            default: return -($urandom() >> $urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Divide by zero in both modes, the wrapping minus-one case, sign
        // combinations and the extremes of both operands.
        send_operands(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_operands(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_operands(32'h8000_0000, 32'h0000_0000, 1'b0);
        send_operands(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_operands(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_operands(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_operands(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_operands(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_operands(32'h8000_0000, 32'h0000_0001, 1'b1);
        send_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_operands(-32'sd7, 32'd2, 1'b1);
        send_operands(32'd7, -32'sd2, 1'b1);
        send_operands(-32'sd7, -32'sd2, 1'b1);
        send_operands(32'd7, 32'd2, 1'b1);
        send_operands(-32'sd7, 32'd2, 1'b0);
        send_operands(32'd5, 32'd10, 1'b0);
        send_operands(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_operands(32'h1234_5678, 32'h0000_0001, 1'b1);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

        for (int n = 0; n < RandomWords; n++) begin
            no_gaps <= (n >= 1100 && n < 1400);
            send_operands(random_operand(), random_operand(), 1'($urandom_range(0, 1)));
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d divides: %0d signed, %0d with a zero divisor, %0d results checked.",
                 sb.words_in, sb.signed_words, sb.zero_divisors, sb.words_out);
        $display("Output held off for %0d cycles (done=%0d); input waited %0d of them.",
                 HoldOffCycles, hold_off_done, held_input_cycles);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/idwr_pkg.sv
rtl/idwr_pre.sv
rtl/idwr_step.sv
rtl/idwr_post.sv
rtl/integer_divide_with_remainder.sv
sim/tb_top.sv
